>>> src/pdf_pkg.sv
// Shared constants, codes and types of the Poisson-disc dart filter.
// No dependencies; every other file but pdf_ram imports this package.
`timescale 1ns / 1ps
package pdf_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS = 12;
  localparam int SCALE_BITS = 32;
  localparam int SCALE_FRAC = 24;
  localparam int GRID_DIM_W = 7;
  localparam int DIST_W = 50;
  localparam int CFG_W = 50;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W = 12;
  localparam int STATUS_W = 2;
  localparam int NBR_SPAN = 5;

  localparam int GRID_DIM_MAX_DEF = 64;
  localparam int MAX_SAMPLES_DEF = 4096;

  localparam int IN_FIELDS_W = 2 * COORD_BITS;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [COORD_BITS-1:0] TILE_SIZE_RST = 24'd1048576;
  localparam logic [GRID_DIM_W-1:0] GRID_DIM_RST = 7'd46;
  localparam logic [SCALE_BITS-1:0] CELL_SCALE_RST = 32'd3014656;
  localparam logic [DIST_W-1:0] MIN_DIST_SQ_RST = 50'd1079110533;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_SIZE   = 2'd0,
    REG_GRID_DIM    = 2'd1,
    REG_CELL_SCALE  = 2'd2,
    REG_MIN_DIST_SQ = 2'd3
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ACCEPT  = 2'd0,
    STATUS_COLLIDE = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  // Travels with each neighbour lookup: whether it is live and which tile edge it crosses.
  typedef struct packed {
    logic valid;
    logic x_neg;
    logic x_pos;
    logic y_neg;
    logic y_pos;
  } scan_tag_t;

endpackage

>>> src/pdf_ram.sv
// Simple dual-port synchronous memory, one write and one registered read port.
// Depends on nothing; used for the cell owner grid and the sample store.
`timescale 1ns / 1ps
module pdf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/pdf_cell_map.sv
// Maps a candidate point to its grid cell: scale multiply, then saturation.
// Depends on pdf_pkg; two register stages.
`timescale 1ns / 1ps
module pdf_cell_map import pdf_pkg::*; #(
  parameter int GRID_DIM_MAX = GRID_DIM_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic [COORD_BITS-1:0]               coord_x_i,
  input  logic [COORD_BITS-1:0]               coord_y_i,
  input  logic [SCALE_BITS-1:0]               scale_i,
  input  logic [$clog2(GRID_DIM_MAX+1)-1:0]   dim_i,
  output logic [$clog2(GRID_DIM_MAX)-1:0]     cell_x_o,
  output logic [$clog2(GRID_DIM_MAX)-1:0]     cell_y_o
);

  localparam int CELL_W = $clog2(GRID_DIM_MAX);
  localparam int DIM_W = $clog2(GRID_DIM_MAX + 1);
  localparam int PROD_W = COORD_BITS + SCALE_BITS;
  localparam int SHIFT = FRAC_BITS + SCALE_FRAC;
  localparam int CW = PROD_W - SHIFT;

  logic [PROD_W-1:0] prod_x_q, prod_y_q;
  logic [CW-1:0]     raw_x, raw_y;
  logic [CELL_W-1:0] top_cell;

  always_ff @(posedge clk_i) begin
    prod_x_q <= PROD_W'(coord_x_i) * PROD_W'(scale_i);
    prod_y_q <= PROD_W'(coord_y_i) * PROD_W'(scale_i);
  end

  assign raw_x = prod_x_q[PROD_W-1:SHIFT];
  assign raw_y = prod_y_q[PROD_W-1:SHIFT];
  assign top_cell = CELL_W'(dim_i - DIM_W'(1));

  always_ff @(posedge clk_i) begin
    cell_x_o <= (raw_x >= CW'(dim_i)) ? top_cell : CELL_W'(raw_x);
    cell_y_o <= (raw_y >= CW'(dim_i)) ? top_cell : CELL_W'(raw_y);
  end

endmodule

>>> src/pdf_dist.sv
// Squared-distance test of one stored sample against the candidate, with tile wrap.
// Depends on pdf_pkg; three register stages from sample data to hit flag.
`timescale 1ns / 1ps
module pdf_dist import pdf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_tag_t             tag_i,
  input  logic [COORD_BITS-1:0] samp_x_i,
  input  logic [COORD_BITS-1:0] samp_y_i,
  input  logic [COORD_BITS-1:0] cand_x_i,
  input  logic [COORD_BITS-1:0] cand_y_i,
  input  logic [COORD_BITS-1:0] tile_i,
  input  logic [DIST_W-1:0]     min_dist_sq_i,
  output logic                  hit_o
);

  localparam int DD_W = COORD_BITS + 3;
  localparam int SQ_W = 2 * DD_W;
  localparam int SUM_W = SQ_W + 1;

  logic signed [DD_W-1:0] tile_s, ddx, ddy;
  logic [DD_W-1:0]        adx_q, ady_q;
  logic [SQ_W-1:0]        sqx_q, sqy_q;
  logic [SUM_W-1:0]       d2;
  logic                   va_q, vb_q, hit_q;

  always_comb begin
    tile_s = signed'(DD_W'(tile_i));
    ddx = signed'(DD_W'(samp_x_i)) - signed'(DD_W'(cand_x_i));
    ddy = signed'(DD_W'(samp_y_i)) - signed'(DD_W'(cand_y_i));
    if (tag_i.x_pos) begin
      ddx = ddx + tile_s;
    end else if (tag_i.x_neg) begin
      ddx = ddx - tile_s;
    end
    if (tag_i.y_pos) begin
      ddy = ddy + tile_s;
    end else if (tag_i.y_neg) begin
      ddy = ddy - tile_s;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q <= (ddx < 0) ? unsigned'(-ddx) : unsigned'(ddx);
    ady_q <= (ddy < 0) ? unsigned'(-ddy) : unsigned'(ddy);
    sqx_q <= SQ_W'(adx_q) * SQ_W'(adx_q);
    sqy_q <= SQ_W'(ady_q) * SQ_W'(ady_q);
  end

  assign d2 = SUM_W'(sqx_q) + SUM_W'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      va_q <= tag_i.valid;
      vb_q <= va_q;
      hit_q <= vb_q && (d2 < SUM_W'(min_dist_sq_i));
    end
  end

  assign hit_o = hit_q;

endmodule

>>> src/poisson_disc_dart_filter.sv
// Poisson-disc dart filter: 5x5 toroidal neighbour check against a cell-owner grid.
// Depends on pdf_pkg, pdf_ram, pdf_cell_map and pdf_dist.
// One candidate at a time: no new input word is taken until the last one's verdict is
// issued, a pace set by the 25 owner reads on the grid memory's single read port and
// the six-stage owner/sample/distance pipeline behind it.
// Reset: a clearing pass zeroes all GRID_DIM_MAX*GRID_DIM_MAX entries (4096 by default)
// and empties the grid; no input word is taken meanwhile, configuration writes are.
`timescale 1ns / 1ps
module poisson_disc_dart_filter import pdf_pkg::*; #(
  parameter int GRID_DIM_MAX = GRID_DIM_MAX_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cand_x, cand_y
  input  logic                   s_axis_tlast,   // final_dart
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // status, sample_index, zero pad
  output logic                   m_axis_tlast    // last_dart
);

  localparam int GRID_DEPTH = GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int GRID_AW = $clog2(GRID_DEPTH);
  localparam int OWN_W = $clog2(MAX_SAMPLES + 1);
  localparam int SAMP_AW = $clog2(MAX_SAMPLES);
  localparam int CELL_W = $clog2(GRID_DIM_MAX);
  localparam int DIM_W = $clog2(GRID_DIM_MAX + 1);
  localparam int CI_W = DIM_W + 2;
  localparam int STEP_W = $clog2(NBR_SPAN);
  localparam int DRAIN_LEN = 5;
  localparam int DRAIN_W = $clog2(DRAIN_LEN + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_SAT    = 3'd3;
  localparam logic [2:0] ST_SETUP  = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_DRAIN  = 3'd6;
  localparam logic [2:0] ST_DECIDE = 3'd7;

  function automatic logic [GRID_AW-1:0] grid_addr(logic [CELL_W-1:0] gx,
                                                   logic [CELL_W-1:0] gy);
    return GRID_AW'(GRID_AW'(gx) * GRID_AW'(GRID_DIM_MAX) + GRID_AW'(gy));
  endfunction

  logic [2:0] state_q, state_d;

  logic [COORD_BITS-1:0] tile_q;
  logic [GRID_DIM_W-1:0] grid_dim_q;
  logic [SCALE_BITS-1:0] scale_q;
  logic [DIST_W-1:0]     min_dist_q;

  logic [COORD_BITS-1:0] cand_x_q, cand_y_q;
  logic                  last_q;

  logic [GRID_AW-1:0]    clr_q;
  logic [OWN_W-1:0]      cnt_q;
  logic [DIM_W-1:0]      dim_eff;
  logic [CELL_W-1:0]     cell_x, cell_y;

  logic signed [CI_W-1:0] dim_s, wrap_x, wrap_y, ci_q, cj_q;
  logic [CELL_W-1:0]     gi_q, gj_q, gi0_q, gi_inc, gj_inc;
  logic [STEP_W-1:0]     step_x_q, step_y_q;
  logic [DRAIN_W-1:0]    drain_q;
  logic                  hit_q, dist_hit;
  logic                  last_step, row_end;

  scan_tag_t             s1_tag_q, s2_tag_q, scan_tag;

  logic                  own_we;
  logic [GRID_AW-1:0]    own_waddr;
  logic [OWN_W-1:0]      own_wdata, own_rdata;
  logic [2*COORD_BITS-1:0] samp_rdata;

  logic                  go, full, accept_ins;

  logic                  out_valid_q, out_last_q;
  status_e               out_status_q;
  logic [IDX_W-1:0]      out_idx_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q <= TILE_SIZE_RST;
      grid_dim_q <= GRID_DIM_RST;
      scale_q <= CELL_SCALE_RST;
      min_dist_q <= MIN_DIST_SQ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TILE_SIZE:   tile_q <= cfg_data_i[COORD_BITS-1:0];
        REG_GRID_DIM:    grid_dim_q <= cfg_data_i[GRID_DIM_W-1:0];
        REG_CELL_SCALE:  scale_q <= cfg_data_i[SCALE_BITS-1:0];
        REG_MIN_DIST_SQ: min_dist_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_dim_q == '0) begin
      dim_eff = DIM_W'(1);
    end else if (int'(grid_dim_q) > GRID_DIM_MAX) begin
      dim_eff = DIM_W'(GRID_DIM_MAX);
    end else begin
      dim_eff = DIM_W'(grid_dim_q);
    end
  end

  pdf_cell_map #(
    .GRID_DIM_MAX(GRID_DIM_MAX)
  ) u_cell_map (
    .clk_i     (clk_i),
    .coord_x_i (cand_x_q),
    .coord_y_i (cand_y_q),
    .scale_i   (scale_q),
    .dim_i     (dim_eff),
    .cell_x_o  (cell_x),
    .cell_y_o  (cell_y)
  );

  // Start of the neighbour walk, taken modulo the grid size.
  always_comb begin
    dim_s = signed'(CI_W'(dim_eff));
    wrap_x = signed'(CI_W'(cell_x)) - signed'(CI_W'(2));
    wrap_y = signed'(CI_W'(cell_y)) - signed'(CI_W'(2));
    if (wrap_x < 0) begin
      wrap_x = wrap_x + dim_s;
    end
    if (wrap_x < 0) begin
      wrap_x = wrap_x + dim_s;
    end
    if (wrap_y < 0) begin
      wrap_y = wrap_y + dim_s;
    end
    if (wrap_y < 0) begin
      wrap_y = wrap_y + dim_s;
    end
  end

  assign gi_inc = (DIM_W'(gi_q) + DIM_W'(1) == dim_eff) ? '0 : gi_q + CELL_W'(1);
  assign gj_inc = (DIM_W'(gj_q) + DIM_W'(1) == dim_eff) ? '0 : gj_q + CELL_W'(1);
  assign row_end = (step_x_q == STEP_W'(NBR_SPAN - 1));
  assign last_step = row_end && (step_y_q == STEP_W'(NBR_SPAN - 1));

  always_comb begin
    scan_tag.valid = 1'b1;
    scan_tag.x_neg = (ci_q < 0);
    scan_tag.x_pos = (ci_q >= dim_s);
    scan_tag.y_neg = (cj_q < 0);
    scan_tag.y_pos = (cj_q >= dim_s);
  end

  assign full = (cnt_q >= OWN_W'(MAX_SAMPLES));
  assign go = (state_q == ST_DECIDE) && (!out_valid_q || m_axis_tready);
  assign accept_ins = go && !hit_q && !full;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == GRID_AW'(GRID_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_MUL;
      ST_MUL:    state_d = ST_SAT;
      ST_SAT:    state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_SCAN;
      ST_SCAN:   if (last_step) state_d = ST_DRAIN;
      ST_DRAIN:  if (drain_q == DRAIN_W'(DRAIN_LEN - 1)) state_d = ST_DECIDE;
      ST_DECIDE: if (go) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
      drain_q <= '0;
      step_x_q <= '0;
      step_y_q <= '0;
      hit_q <= 1'b0;
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + GRID_AW'(1);
      end
      if (state_q == ST_SETUP) begin
        step_x_q <= '0;
        step_y_q <= '0;
        hit_q <= 1'b0;
      end else if (dist_hit) begin
        hit_q <= 1'b1;
      end
      if (state_q == ST_SCAN) begin
        step_x_q <= row_end ? '0 : step_x_q + STEP_W'(1);
        if (row_end) begin
          step_y_q <= step_y_q + STEP_W'(1);
        end
      end
      drain_q <= (state_q == ST_DRAIN) ? drain_q + DRAIN_W'(1) : '0;
      s1_tag_q <= (state_q == ST_SCAN) ? scan_tag : '0;
      s2_tag_q <= '{valid: s1_tag_q.valid && (own_rdata != '0),
                    x_neg: s1_tag_q.x_neg,
                    x_pos: s1_tag_q.x_pos,
                    y_neg: s1_tag_q.y_neg,
                    y_pos: s1_tag_q.y_pos};
      if (accept_ins) begin
        cnt_q <= cnt_q + OWN_W'(1);
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cand_x_q <= s_axis_tdata[COORD_BITS-1:0];
      cand_y_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_SETUP) begin
      ci_q <= signed'(CI_W'(cell_x)) - signed'(CI_W'(2));
      cj_q <= signed'(CI_W'(cell_y)) - signed'(CI_W'(2));
      gi_q <= CELL_W'(wrap_x);
      gi0_q <= CELL_W'(wrap_x);
      gj_q <= CELL_W'(wrap_y);
    end else if (state_q == ST_SCAN) begin
      if (row_end) begin
        ci_q <= signed'(CI_W'(cell_x)) - signed'(CI_W'(2));
        gi_q <= gi0_q;
        cj_q <= cj_q + signed'(CI_W'(1));
        gj_q <= gj_inc;
      end else begin
        ci_q <= ci_q + signed'(CI_W'(1));
        gi_q <= gi_inc;
      end
    end
    if (go) begin
      out_last_q <= last_q;
      if (hit_q) begin
        out_status_q <= STATUS_COLLIDE;
        out_idx_q <= '0;
      end else if (full) begin
        out_status_q <= STATUS_FULL;
        out_idx_q <= '0;
      end else begin
        out_status_q <= STATUS_ACCEPT;
        out_idx_q <= IDX_W'(cnt_q);
      end
    end
  end

  assign own_we = (state_q == ST_CLEAR) || accept_ins;
  assign own_waddr = (state_q == ST_CLEAR) ? clr_q : grid_addr(cell_x, cell_y);
  assign own_wdata = (state_q == ST_CLEAR) ? '0 : cnt_q + OWN_W'(1);

  pdf_ram #(
    .DEPTH(GRID_DEPTH),
    .WIDTH(OWN_W)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (grid_addr(gi_q, gj_q)),
    .rdata_o (own_rdata)
  );

  pdf_ram #(
    .DEPTH(MAX_SAMPLES),
    .WIDTH(2 * COORD_BITS)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (accept_ins),
    .waddr_i (SAMP_AW'(cnt_q)),
    .wdata_i ({cand_y_q, cand_x_q}),
    .raddr_i (SAMP_AW'(own_rdata - OWN_W'(1))),
    .rdata_o (samp_rdata)
  );

  pdf_dist u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (s2_tag_q),
    .samp_x_i      (samp_rdata[COORD_BITS-1:0]),
    .samp_y_i      (samp_rdata[2*COORD_BITS-1:COORD_BITS]),
    .cand_x_i      (cand_x_q),
    .cand_y_i      (cand_y_q),
    .tile_i        (tile_q),
    .min_dist_sq_i (min_dist_q),
    .hit_o         (dist_hit)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = OUT_TDATA_W'({out_idx_q, out_status_q});
  assign m_axis_tlast = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OWN_W'(MAX_SAMPLES))
    else $error("sample count beyond store size");

  a_insert_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_ins |=> cnt_q == $past(cnt_q) + OWN_W'(1))
    else $error("sample count did not advance on insert");

  a_result_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DECIDE)
    else $error("result word raised outside the decision step");

  a_no_lookup_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_CLEAR) |-> !s2_tag_q.valid && !dist_hit)
    else $error("neighbour lookup live while no candidate is held");

endmodule

>>> dv/tb_poisson_disc_dart_filter.sv
// Self-checking testbench for the Poisson-disc dart filter: candidate words go in over the
// input stream, and each verdict word is checked against a behavioural model of the grid.
// Depends on pdf_pkg and poisson_disc_dart_filter only.
`timescale 1ns / 1ps
module tb_poisson_disc_dart_filter;
  import pdf_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [IDX_W-1:0]    index;
    logic                last;
  } dart_verdict_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = REG_TILE_SIZE;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Model of the block's registers and stores.
  logic [COORD_BITS-1:0] cfg_tile = TILE_SIZE_RST;
  logic [GRID_DIM_W-1:0] cfg_dim = GRID_DIM_RST;
  logic [SCALE_BITS-1:0] cfg_scale = CELL_SCALE_RST;
  logic [DIST_W-1:0]     cfg_mdsq = MIN_DIST_SQ_RST;
  logic [IDX_W:0]        owner_of [GRID_DIM_MAX_DEF*GRID_DIM_MAX_DEF] = '{default: '0};
  logic [COORD_BITS-1:0] stored_x [MAX_SAMPLES_DEF];
  logic [COORD_BITS-1:0] stored_y [MAX_SAMPLES_DEF];
  int unsigned           n_stored = 0;

  dart_verdict_t pending_verdicts[$];
  int unsigned   n_errors = 0;
  int unsigned   src_idle_pct = 0;
  int unsigned   sink_idle_pct = 0;

  poisson_disc_dart_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // cand_x, cand_y
    .s_axis_tlast  (s_axis_tlast),   // final_dart
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // status, sample_index, zero pad
    .m_axis_tlast  (m_axis_tlast)    // last_dart
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic flag_mismatch(string msg);
    if (n_errors < 200) begin
      $display("%0t ns: %s", $time, msg);
    end
    n_errors++;
  endtask

  function automatic int dim_used();
    if (cfg_dim == 0) return 1;
    if (cfg_dim > GRID_DIM_MAX_DEF) return GRID_DIM_MAX_DEF;
    return int'(cfg_dim);
  endfunction

  function automatic int cell_of(logic [COORD_BITS-1:0] c, int d);
    logic [63:0] p;
    p = ({40'd0, c} * {32'd0, cfg_scale}) >> (FRAC_BITS + SCALE_FRAC);
    return (p >= 64'(d)) ? d - 1 : int'(p);
  endfunction

  // Works out the verdict for one candidate and commits an accepted one to the stores.
  function automatic dart_verdict_t judge_dart(logic [COORD_BITS-1:0] cx,
                                               logic [COORD_BITS-1:0] cy, logic fin);
    int d, xk, yk, ci, cj, gi, gj, ox, oy;
    logic [IDX_W:0] own;
    longint s, ddx, ddy;
    logic [63:0] d2;
    logic hit;
    dart_verdict_t v;
    d = dim_used();
    xk = cell_of(cx, d);
    yk = cell_of(cy, d);
    s = longint'(cfg_tile);
    hit = 1'b0;
    for (int dy = -2; dy <= 2 && !hit; dy++) begin
      for (int dx = -2; dx <= 2 && !hit; dx++) begin
        ci = xk + dx;
        cj = yk + dy;
        ox = (ci < 0) ? -1 : (ci >= d) ? 1 : 0;
        oy = (cj < 0) ? -1 : (cj >= d) ? 1 : 0;
        gi = (ci + 2 * d) % d;
        gj = (cj + 2 * d) % d;
        own = owner_of[gi * GRID_DIM_MAX_DEF + gj];
        if (own != 0 && own <= MAX_SAMPLES_DEF) begin
          ddx = longint'(stored_x[own - 1'b1]) + ox * s - longint'(cx);
          ddy = longint'(stored_y[own - 1'b1]) + oy * s - longint'(cy);
          d2 = ddx * ddx + ddy * ddy;
          if (d2 < {14'd0, cfg_mdsq}) hit = 1'b1;
        end
      end
    end
    v.last = fin;
    v.index = '0;
    if (hit) begin
      v.status = STATUS_COLLIDE;
    end else if (n_stored >= MAX_SAMPLES_DEF) begin
      v.status = STATUS_FULL;
    end else begin
      stored_x[n_stored] = cx;
      stored_y[n_stored] = cy;
      owner_of[xk * GRID_DIM_MAX_DEF + yk] = (IDX_W + 1)'(n_stored + 1);
      v.index = IDX_W'(n_stored);
      v.status = STATUS_ACCEPT;
      n_stored++;
    end
    return v;
  endfunction

  always @(posedge clk_i) begin : check_words
    dart_verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("verdict word with no candidate outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[STATUS_W-1:0] !== want.status) begin
          flag_mismatch($sformatf("status %0d, expected %0d",
                                  m_axis_tdata[STATUS_W-1:0], want.status));
        end
        if (m_axis_tdata[STATUS_W +: IDX_W] !== want.index) begin
          flag_mismatch($sformatf("sample_index %0d, expected %0d",
                                  m_axis_tdata[STATUS_W +: IDX_W], want.index));
        end
        if (m_axis_tlast !== want.last) begin
          flag_mismatch($sformatf("last_dart %0b, expected %0b", m_axis_tlast, want.last));
        end
      end
    end
  end

  task automatic send_dart(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy, logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {cy, cx};
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_verdicts.push_back(judge_dart(cx, cy, fin));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [COORD_BITS-1:0] t, logic [GRID_DIM_W-1:0] g,
                             logic [SCALE_BITS-1:0] c, logic [DIST_W-1:0] m);
    drain_results();
    put_reg(REG_TILE_SIZE, CFG_W'(t));
    put_reg(REG_GRID_DIM, CFG_W'(g));
    put_reg(REG_CELL_SCALE, CFG_W'(c));
    put_reg(REG_MIN_DIST_SQ, CFG_W'(m));
    cfg_we_i <= 1'b0;
    cfg_tile = t;
    cfg_dim = g;
    cfg_scale = c;
    cfg_mdsq = m;
  endtask

  // Mostly a consistent tile, grid and radius, now and then an odd register value.
  task automatic load_random_config();
    logic [COORD_BITS-1:0] t;
    int unsigned g;
    logic [63:0] c, m;
    t = COORD_BITS'($urandom_range(24'hFFFFFF, 24'h1000));
    g = $urandom_range(GRID_DIM_MAX_DEF, 1);
    c = (64'(g) << (FRAC_BITS + SCALE_FRAC)) / t;
    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
    m = (64'(t) * t * 201) / (100 * g * g);
    case ($urandom_range(7))
      0: g = $urandom_range(1) ? 0 : $urandom_range(127, GRID_DIM_MAX_DEF + 1);
      1: c = $urandom;
      2: m = {$urandom, $urandom};
      default: ;
    endcase
    load_config(t, GRID_DIM_W'(g), SCALE_BITS'(c), DIST_W'(m));
  endtask

  function automatic logic [COORD_BITS-1:0] near_coord(longint base, longint span, longint t);
    longint v;
    v = base + longint'($urandom_range(2 * span)) - span;
    v = ((v % t) + t) % t;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic send_random_dart();
    longint t, span;
    int unsigned k, mode;
    logic [COORD_BITS-1:0] x, y;
    t = longint'(cfg_tile);
    span = t / dim_used() + 1;
    mode = $urandom_range(99);
    if (mode < 25 && n_stored > 0) begin
      k = $urandom_range(n_stored - 1);
      x = near_coord(stored_x[k], span, t);
      y = near_coord(stored_y[k], span, t);
    end else if (mode < 35) begin
      x = near_coord(0, 40, t);
      y = $urandom_range(1) ? near_coord(0, 40, t) : COORD_BITS'($urandom_range(t - 1));
    end else if (mode < 45) begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
    end else begin
      x = COORD_BITS'($urandom_range(t - 1));
      y = COORD_BITS'($urandom_range(t - 1));
    end
    send_dart(x, y, $urandom_range(7) == 0);
  endtask

  task automatic test_reset_defaults();
    send_dart(24'h000000, 24'h000000, 1'b0);
    send_dart(24'h000000, 24'h000000, 1'b1);
    send_dart(24'h0FFFFF, 24'h0FFFFF, 1'b0);
    send_dart(24'h000000, 24'h0FFFFF, 1'b1);
    send_dart(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_dart(24'h080000, 24'h080000, 1'b0);
    drain_results();
  endtask

  task automatic test_register_extremes();
    load_config(24'hFFFFFF, 7'd127, 32'hFFFF_FFFF, '1);
    send_dart(24'h000005, 24'h000005, 1'b0);
    send_dart(24'h0003E8, 24'h000010, 1'b1);
    send_dart(24'hFFFFFF, 24'h000000, 1'b0);
    load_config(24'h000001, 7'd0, 32'h0, '0);
    send_dart(24'h000000, 24'h000000, 1'b0);
    send_dart(24'hABCDEF, 24'h123456, 1'b1);
    load_config(24'h000001, 7'd1, 32'h0, '1);
    send_dart(24'h000001, 24'h000000, 1'b0);
    drain_results();
  endtask

  task automatic test_small_grids();
    logic [DIST_W-1:0] m;
    for (int g = 2; g <= 4; g++) begin
      m = DIST_W'((64'h1000 * 64'h1000 * 201) / (100 * g * g));
      load_config(24'h001000, GRID_DIM_W'(g), SCALE_BITS'(g) << SCALE_FRAC, m);
      send_dart(24'h00000A, 24'h00000A, 1'b0);
      send_dart(24'h000FFA, 24'h000FFA, 1'b1);
      send_dart(24'h000800, 24'h000005, 1'b0);
    end
    drain_results();
  endtask

  task automatic test_random_darts(int unsigned n_darts);
    for (int unsigned i = 0; i < n_darts; i++) begin
      if (i % 95 == 0) begin
        load_random_config();
      end else if ($urandom_range(59) == 0) begin
        drain_results();
      end
      send_random_dart();
    end
    drain_results();
  endtask

  task automatic test_store_full();
    load_config(TILE_SIZE_RST, GRID_DIM_RST, CELL_SCALE_RST, '0);
    while (n_stored < MAX_SAMPLES_DEF) begin
      send_dart(COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom_range(1));
    end
    repeat (4) send_dart(COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom_range(1));
    // A collision still wins over a full store.
    load_config(TILE_SIZE_RST, GRID_DIM_RST, CELL_SCALE_RST, '1);
    repeat (3) send_dart(COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom_range(1));
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_small_grids();
    src_idle_pct = 16;
    sink_idle_pct = 66;
    test_random_darts(570);
    src_idle_pct = 66;
    sink_idle_pct = 16;
    test_random_darts(570);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_darts(570);
    test_store_full();
    if (n_errors == 0) begin
      $display("poisson_disc_dart_filter test passed");
    end else begin
      $display("poisson_disc_dart_filter test failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("poisson_disc_dart_filter test failed");
    $finish;
  end

endmodule

>>> files.f
src/pdf_pkg.sv
src/pdf_ram.sv
src/pdf_cell_map.sv
src/pdf_dist.sv
src/poisson_disc_dart_filter.sv
dv/tb_poisson_disc_dart_filter.sv
